[src/ilmd_pkg.sv]
// Package: shared constants, codes, types and helpers of the interrupt level mask dispatcher.
`default_nettype none
package ilmd_pkg;

  localparam int LEVEL_COUNT = 8;
  localparam int LEVEL_W     = 3;
  localparam int LVL_IDX_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int LVL_CNT_W   = ($clog2(LEVEL_COUNT + 1) > LEVEL_W + 1) ?
                               $clog2(LEVEL_COUNT + 1) : LEVEL_W + 1;
  localparam int KIND_W      = 2;
  localparam int SRC_W       = 6;
  localparam int STATUS_W    = 2;
  localparam int HALF_W      = 32;
  localparam int HALF_IDX_W  = 5;
  localparam int MASK_W      = 64;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [LEVEL_W-1:0] DISABLED_LEVEL_RESET = 3'd3;
  localparam logic               REG_IRQS_DISABLED_LEVEL = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_REGISTER,
    KIND_SET_LEVEL,
    KIND_EVENT,
    KIND_NOP
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK,
    STATUS_TAKEN,
    STATUS_PENDING
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_CHECK,
    ST_REG_FILL,
    ST_LVL_LOAD,
    ST_LVL_CHECK,
    ST_EV_FILTER,
    ST_EV_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                  found;
    logic [HALF_IDX_W-1:0] index;
  } top_bit_t;

  // byte-reversed bit of a source within its half, high half above bit 31
  function automatic logic [MASK_W-1:0] source_bit(input logic [SRC_W-1:0] src);
    logic [SRC_W-1:0] pos;
    pos = {src[5], ~src[4], ~src[3], src[2:0]};
    return {{(MASK_W-1){1'b0}}, 1'b1} << pos;
  endfunction

endpackage
`default_nettype wire

[src/ilmd_if.sv]
// Interfaces: request and result channels of the interrupt level mask dispatcher.
`default_nettype none
interface ilmd_in_if;
  logic                       valid;
  logic                       ready;
  logic [ilmd_pkg::KIND_W-1:0]  kind;
  logic [ilmd_pkg::SRC_W-1:0]   source_id;
  logic [ilmd_pkg::LEVEL_W-1:0] level;
  logic [ilmd_pkg::LEVEL_W-1:0] prior_level;
  logic                       lowering;
  logic [ilmd_pkg::HALF_W-1:0]  events_low;
  logic [ilmd_pkg::HALF_W-1:0]  events_high;

  modport source (output valid, kind, source_id, level, prior_level, lowering, events_low,
                  events_high, input ready);
  modport sink   (input valid, kind, source_id, level, prior_level, lowering, events_low,
                  events_high, output ready);
endinterface

interface ilmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ilmd_pkg::STATUS_W-1:0] status;
  logic                          dispatch_valid;
  logic [ilmd_pkg::SRC_W-1:0]    dispatched_source;
  logic                          last;
  logic                          fake_interrupt;
  logic                          mask_write;
  logic [ilmd_pkg::HALF_W-1:0]   mask_low;
  logic [ilmd_pkg::HALF_W-1:0]   mask_high;
  logic [ilmd_pkg::LEVEL_W-1:0]  new_level;

  modport source (output valid, status, dispatch_valid, dispatched_source, last,
                  fake_interrupt, mask_write, mask_low, mask_high, new_level, input ready);
  modport sink   (input valid, status, dispatch_valid, dispatched_source, last,
                  fake_interrupt, mask_write, mask_low, mask_high, new_level, output ready);
endinterface
`default_nettype wire

[src/ilmd_top_bit.sv]
// Priority encoder: highest set bit of one 32-bit event half.
`default_nettype none
module ilmd_top_bit (
  input  logic [ilmd_pkg::HALF_W-1:0] word,
  output ilmd_pkg::top_bit_t          result
);
  import ilmd_pkg::*;

  always_comb begin
    result.found = |word;
    result.index = '0;
    for (int i = 0; i < HALF_W; i++) begin
      if (word[i]) begin
        result.index = HALF_IDX_W'(i);
      end
    end
  end

endmodule
`default_nettype wire

[src/interrupt_level_mask_dispatcher.sv]
// Top level: 64-source interrupt controller with priority-level masks and serial dispatch.
//
// Requests enter on in_ch (valid/ready); a transaction is taken when both are high.
// in_ch.ready is high only while the sequencer is idle, so one request is worked at a time.
// Results leave on out_ch through an output register; the next request may be taken while
// the final result of the previous one still waits there.
// Register source: a check state, then a fill state that adds the source to each level mask
//   from level+1 up to LEVEL_COUNT-1 (skipped when the source is taken or pending), then an
//   emit state to load the single result.
// Set level: load desired mask, compare with hardware mask, load result.
// Event sample: a filter state, then one result per dispatched source (one 32-bit priority
//   encoder, shared by both halves, picks each source), at least one result.
// The level masks are updated one level per cycle; one result is produced per cycle at most.
// A stalled receiver holds the result register and stops the sequencer at its next result.
// Reset (rst, synchronous) clears all masks and source sets, sets the level to
//   LEVEL_COUNT-1 and irqs_disabled_level to 3, and empties the result register.
// Configuration: APB write of irqs_disabled_level at byte address 0; pready is tied high.
`default_nettype none
module interrupt_level_mask_dispatcher (
  input  logic                          clk,
  input  logic                          rst,
  ilmd_in_if.sink                       in_ch,
  ilmd_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ilmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [ilmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [ilmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import ilmd_pkg::*;

  state_t state, state_next;

  logic [MASK_W-1:0]  level_masks [LEVEL_COUNT];
  logic [MASK_W-1:0]  enabled_sources;
  logic [MASK_W-1:0]  registered_sources;
  logic [MASK_W-1:0]  pending_sources;
  logic [MASK_W-1:0]  desired_mask;
  logic [MASK_W-1:0]  current_mask;
  logic [LEVEL_W-1:0] current_level;
  logic [LEVEL_W-1:0] irqs_disabled_level;

  logic [MASK_W-1:0]  src_bit;
  logic [LEVEL_W-1:0] lv_r;
  logic [LEVEL_W-1:0] old_r;
  logic               low_r;
  logic [MASK_W-1:0]  ev_r;
  logic [MASK_W-1:0]  work;
  logic [LVL_CNT_W-1:0] cnt;
  logic [LEVEL_W-1:0] nl_r;
  logic               upd_r;
  status_t            st_r;
  logic               fake_r;
  logic               mw_r;

  logic               out_valid_r;
  logic               in_take;
  logic               out_free;
  logic               cfg_write;

  logic [LEVEL_W-1:0] nl_raw;
  logic [LEVEL_W-1:0] nl;
  logic [MASK_W-1:0]  irq;
  logic               ev_hit;
  logic               sel_hi;
  logic [HALF_W-1:0]  scan_word;
  top_bit_t           tb;
  logic [MASK_W-1:0]  work_cleared;
  logic               scan_last;

  logic               emit;
  status_t            e_status;
  logic               e_dv;
  logic [SRC_W-1:0]   e_ds;
  logic               e_last;
  logic               e_fake;
  logic               e_mw;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite &&
                     (paddr[PADDR_W-1:2] == REG_IRQS_DISABLED_LEVEL);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_IRQS_DISABLED_LEVEL) ?
                     {{(PDATA_W-LEVEL_W){1'b0}}, irqs_disabled_level} : '0;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;

  assign nl_raw = (!low_r && (lv_r > old_r)) ? old_r : lv_r;
  assign nl     = (32'(nl_raw) >= LEVEL_COUNT) ? LEVEL_W'(LEVEL_COUNT - 1) : nl_raw;

  assign irq    = (ev_r | pending_sources) & enabled_sources;
  assign ev_hit = |(ev_r & ~desired_mask);

  assign sel_hi    = (work[HALF_W-1:0] == '0);
  assign scan_word = sel_hi ? work[MASK_W-1:HALF_W] : work[HALF_W-1:0];

  ilmd_top_bit u_top_bit (
    .word   (scan_word),
    .result (tb)
  );

  assign work_cleared = work & ~({{(MASK_W-1){1'b0}}, 1'b1} << {sel_hi, tb.index});
  assign scan_last    = (work_cleared == '0);

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    e_status   = STATUS_OK;
    e_dv       = 1'b0;
    e_ds       = '0;
    e_last     = 1'b1;
    e_fake     = 1'b0;
    e_mw       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (kind_t'(in_ch.kind))
            KIND_REGISTER:  state_next = ST_REG_CHECK;
            KIND_SET_LEVEL: state_next = ST_LVL_LOAD;
            KIND_EVENT:     state_next = ST_EV_FILTER;
            default:        state_next = ST_EMIT;
          endcase
        end
      end
      ST_REG_CHECK: begin
        if (|(registered_sources & src_bit) || |(pending_sources & src_bit)) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_REG_FILL;
        end
      end
      ST_REG_FILL: begin
        if (32'(cnt) >= LEVEL_COUNT) begin
          state_next = ST_EMIT;
        end
      end
      ST_LVL_LOAD:  state_next = ST_LVL_CHECK;
      ST_LVL_CHECK: state_next = ST_EMIT;
      ST_EV_FILTER: state_next = ST_EV_SCAN;
      ST_EV_SCAN: begin
        if (out_free) begin
          emit   = 1'b1;
          e_mw   = mw_r;
          e_dv   = (work != '0);
          e_ds   = (work != '0) ? {sel_hi, tb.index} : '0;
          e_last = (work == '0) || scan_last;
          if (e_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          e_status   = st_r;
          e_fake     = fake_r;
          e_mw       = mw_r;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVEL_COUNT; i++) begin
        level_masks[i] <= '0;
      end
      enabled_sources     <= '0;
      registered_sources  <= '0;
      pending_sources     <= '0;
      desired_mask        <= '0;
      current_mask        <= '0;
      current_level       <= LEVEL_W'(LEVEL_COUNT - 1);
      irqs_disabled_level <= DISABLED_LEVEL_RESET;
      out_valid_r         <= 1'b0;
    end else begin
      if (cfg_write) begin
        irqs_disabled_level <= pwdata[LEVEL_W-1:0];
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state)
        ST_REG_CHECK: begin
          if (!(|(registered_sources & src_bit)) && !(|(pending_sources & src_bit))) begin
            registered_sources <= registered_sources | src_bit;
            enabled_sources    <= enabled_sources | src_bit;
          end
        end
        ST_REG_FILL: begin
          if (32'(cnt) < LEVEL_COUNT) begin
            level_masks[cnt[LVL_IDX_W-1:0]] <= level_masks[cnt[LVL_IDX_W-1:0]] | src_bit;
          end
        end
        ST_LVL_LOAD: begin
          current_level <= nl;
          if (nl > irqs_disabled_level) begin
            desired_mask <= level_masks[LVL_IDX_W'(nl)];
          end
        end
        ST_LVL_CHECK: begin
          if (upd_r && (old_r < nl_r) && ((current_mask & desired_mask) != desired_mask)) begin
            current_mask <= desired_mask;
          end
        end
        ST_EV_FILTER: begin
          if (ev_hit) begin
            current_mask    <= desired_mask;
            pending_sources <= (pending_sources | irq) & ~(irq & desired_mask);
          end else begin
            pending_sources <= pending_sources & ~(irq & desired_mask);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          src_bit <= source_bit(in_ch.source_id);
          lv_r    <= in_ch.level;
          old_r   <= in_ch.prior_level;
          low_r   <= in_ch.lowering;
          ev_r    <= {in_ch.events_high, in_ch.events_low};
          cnt     <= LVL_CNT_W'(in_ch.level) + LVL_CNT_W'(1);
          st_r    <= STATUS_OK;
          fake_r  <= 1'b0;
          mw_r    <= 1'b0;
        end
      end
      ST_REG_CHECK: begin
        if (|(registered_sources & src_bit)) begin
          st_r <= STATUS_TAKEN;
        end else if (|(pending_sources & src_bit)) begin
          st_r <= STATUS_PENDING;
        end
      end
      ST_REG_FILL: begin
        if (32'(cnt) < LEVEL_COUNT) begin
          cnt <= cnt + LVL_CNT_W'(1);
        end
      end
      ST_LVL_LOAD: begin
        nl_r  <= nl;
        upd_r <= (nl > irqs_disabled_level);
      end
      ST_LVL_CHECK: begin
        if (upd_r && (old_r < nl_r)) begin
          if ((current_mask & desired_mask) != desired_mask) begin
            mw_r <= 1'b1;
          end
          if (|(pending_sources & desired_mask)) begin
            fake_r <= 1'b1;
          end
        end
      end
      ST_EV_FILTER: begin
        mw_r <= ev_hit;
        work <= irq & desired_mask;
      end
      ST_EV_SCAN: begin
        if (emit) begin
          mw_r <= 1'b0;
          if (work != '0) begin
            work <= work_cleared;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_ch.status            <= e_status;
      out_ch.dispatch_valid    <= e_dv;
      out_ch.dispatched_source <= e_ds;
      out_ch.last              <= e_last;
      out_ch.fake_interrupt    <= e_fake;
      out_ch.mask_write        <= e_mw;
      out_ch.mask_low          <= current_mask[HALF_W-1:0];
      out_ch.mask_high         <= current_mask[MASK_W-1:HALF_W];
      out_ch.new_level         <= current_level;
    end
  end

endmodule
`default_nettype wire

[src/ilmd_checker.sv]
// Checker: port-level assertions of the interrupt level mask dispatcher, bound to the top level.
`default_nettype none
module ilmd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ilmd_pkg::STATUS_W-1:0] out_status,
  input logic                          out_dispatch_valid,
  input logic [ilmd_pkg::SRC_W-1:0]    out_dispatched_source,
  input logic                          out_last,
  input logic                          out_mask_write
);
  import ilmd_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous request still in progress");

  a_busy_mid_dispatch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |-> !in_ready)
    else $error("ready raised before final result of a transaction");

  a_error_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_status != STATUS_OK)) |->
      (out_last && !out_dispatch_valid && !out_mask_write))
    else $error("error status on a result that is not a lone final result");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_status) && $stable(out_dispatched_source) &&
       $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind interrupt_level_mask_dispatcher ilmd_checker u_ilmd_checker (
  .clk                   (clk),
  .rst                   (rst),
  .in_valid              (in_ch.valid),
  .in_ready              (in_ch.ready),
  .out_valid             (out_ch.valid),
  .out_ready             (out_ch.ready),
  .out_status            (out_ch.status),
  .out_dispatch_valid    (out_ch.dispatch_valid),
  .out_dispatched_source (out_ch.dispatched_source),
  .out_last              (out_ch.last),
  .out_mask_write        (out_ch.mask_write)
);
`default_nettype wire
